// File: rtl/core/breath_rate_detector_unit_macros.svh
// Assertion helpers shared by the breath rate detector RTL.
`ifndef BREATH_RATE_DETECTOR_UNIT_MACROS_SVH
`define BREATH_RATE_DETECTOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define BRD_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("same-cycle implication check failed");

// Next-cycle implication, disabled while reset is low
`define BRD_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("next-cycle implication check failed");

`endif

// File: rtl/core/brd_pkg.sv
package brd_pkg;

    // Build-time defaults
    localparam int CAL_SAMPLES_DEF    = 30;
    localparam int REBASE_SAMPLES_DEF = 20;
    localparam int MAG_BITS_DEF       = 18;

    // Fixed field widths
    localparam int MAG_FIELD_W = 18;
    localparam int STAMP_W     = 32;
    localparam int LIM_W       = 18;
    localparam int HOLD_W      = 16;
    localparam int RATE_W      = 8;
    localparam int CNT_W       = 5;

    // Stream layouts
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_USER_W = 3;
    localparam int USR_SEEN   = 0;
    localparam int USR_MOTION = 1;
    localparam int USR_AVG    = 2;

    // Rate arithmetic
    localparam int RATE_NUM = 60000;
    localparam logic [RATE_W-1:0] RATE_MAX = 8'd255;

    // Register reset values
    localparam logic [LIM_W-1:0]  MOTION_RST   = 18'd12051;
    localparam logic [LIM_W-1:0]  REBASE_RST   = 18'd82;
    localparam logic [LIM_W-1:0]  BREATH_RST   = 18'd25;
    localparam logic [HOLD_W-1:0] HOLDOFF_RST  = 16'd1000;
    localparam logic [RATE_W-1:0] CEILING_RST  = 8'd26;
    localparam logic [RATE_W-1:0] FALLBACK_RST = 8'd16;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MOTION   = 3'd0,
        CFG_REBASE   = 3'd1,
        CFG_BREATH   = 3'd2,
        CFG_HOLDOFF  = 3'd3,
        CFG_CEILING  = 3'd4,
        CFG_FALLBACK = 3'd5
    } cfg_idx_t;

    typedef struct packed {
        logic [LIM_W-1:0]  motion_limit;
        logic [LIM_W-1:0]  rebase_limit;
        logic [LIM_W-1:0]  breath_limit;
        logic [HOLD_W-1:0] holdoff_ms;
        logic [RATE_W-1:0] rate_ceiling;
        logic [RATE_W-1:0] fallback_rate;
    } cfg_t;

    // Breath phase codes
    localparam logic [1:0] PH_NONE = 2'd0;
    localparam logic [1:0] PH_ONE  = 2'd1;
    localparam logic [1:0] PH_TWO  = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HOLD,
        ST_EVAL,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

// File: rtl/core/brd_cfg_regs.sv
module brd_cfg_regs (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [brd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [brd_pkg::LIM_W-1:0]      cfg_wdata,
    output brd_pkg::cfg_t                  cfg
);

    brd_pkg::cfg_t cfg_reg;
    brd_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // Decode the write beat; unknown indexes are dropped
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                brd_pkg::CFG_MOTION:   cfg_next.motion_limit  = cfg_wdata;
                brd_pkg::CFG_REBASE:   cfg_next.rebase_limit  = cfg_wdata;
                brd_pkg::CFG_BREATH:   cfg_next.breath_limit  = cfg_wdata;
                brd_pkg::CFG_HOLDOFF:  cfg_next.holdoff_ms    = cfg_wdata[brd_pkg::HOLD_W-1:0];
                brd_pkg::CFG_CEILING:  cfg_next.rate_ceiling  = cfg_wdata[brd_pkg::RATE_W-1:0];
                brd_pkg::CFG_FALLBACK: cfg_next.fallback_rate = cfg_wdata[brd_pkg::RATE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.motion_limit  <= brd_pkg::MOTION_RST;
            cfg_reg.rebase_limit  <= brd_pkg::REBASE_RST;
            cfg_reg.breath_limit  <= brd_pkg::BREATH_RST;
            cfg_reg.holdoff_ms    <= brd_pkg::HOLDOFF_RST;
            cfg_reg.rate_ceiling  <= brd_pkg::CEILING_RST;
            cfg_reg.fallback_rate <= brd_pkg::FALLBACK_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/core/brd_div.sv
module brd_div #(
    parameter int DIVIDEND_W = 23,
    parameter int DIVISOR_W  = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  busy,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int CmpW = (DIVIDEND_W + 1 > DIVISOR_W) ? DIVIDEND_W + 1 : DIVISOR_W;
    localparam int CntW = $clog2(DIVIDEND_W + 1);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CntW-1:0]       cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0] rem_reg, rem_next;
    logic [DIVIDEND_W-1:0] quo_reg, quo_next;
    logic [DIVISOR_W-1:0]  dsr_reg, dsr_next;

    logic [DIVIDEND_W:0]   rem_shift;
    logic [CmpW-1:0]       rem_wide;
    logic [CmpW-1:0]       dsr_wide;
    logic [CmpW-1:0]       diff;
    logic                  fits;

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

    // One restoring step: shift in the next dividend bit, trial subtract
    assign rem_shift = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign rem_wide  = CmpW'(rem_shift);
    assign dsr_wide  = CmpW'(dsr_reg);
    assign fits      = rem_wide >= dsr_wide;
    assign diff      = rem_wide - dsr_wide;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
        end else if (busy_reg) begin
            rem_next = fits ? diff[DIVIDEND_W-1:0] : rem_shift[DIVIDEND_W-1:0];
            quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_next = cnt_reg + CntW'(1);
            if (cnt_reg == CntW'(DIVIDEND_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

endmodule

// File: rtl/core/breath_rate_detector_unit.sv
// A beat is captured in IDLE and goes through HOLD, EVAL and DONE, which registers the
// result beat once the output is free; a beat closing a baseline average or, with a nonzero
// span, a third breath also goes through DIV. s_tready is low from capture until the result
// is registered, also while the shared serial divider runs (one quotient bit per cycle).
// Reset (aresetn low, synchronous): registers to reset values, rate 0, baseline 0,
// and a startup average of CAL_SAMPLES beats armed.
`include "breath_rate_detector_unit_macros.svh"

module breath_rate_detector_unit #(
    parameter int CAL_SAMPLES    = brd_pkg::CAL_SAMPLES_DEF,
    parameter int REBASE_SAMPLES = brd_pkg::REBASE_SAMPLES_DEF,
    parameter int MAG_BITS       = brd_pkg::MAG_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    // config write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [brd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [brd_pkg::LIM_W-1:0]      cfg_wdata,
    // input samples
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [brd_pkg::IN_DATA_W-1:0]  s_tdata,   // magnitude[17:0], stamp_ms[49:18]
    // results
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [brd_pkg::OUT_DATA_W-1:0] m_tdata,   // breaths_per_minute[7:0],
                                                      // baseline_out[25:8]
    output logic [brd_pkg::OUT_USER_W-1:0] m_tuser    // breath_seen[0], motion_reject[1],
                                                      // averaging[2]
);

    localparam int MagW  = (MAG_BITS < brd_pkg::MAG_FIELD_W) ? MAG_BITS : brd_pkg::MAG_FIELD_W;
    localparam int SumW  = MagW + brd_pkg::CNT_W;
    localparam int CntW  = brd_pkg::CNT_W;
    localparam int RateW = brd_pkg::RATE_W;
    localparam int StW   = brd_pkg::STAMP_W;
    localparam int LimW  = brd_pkg::LIM_W;

    brd_pkg::cfg_t cfg;

    brd_pkg::state_t state_reg, state_next;

    // sample and work registers
    logic [MagW-1:0]  mag_reg, mag_next;
    logic [StW-1:0]   stamp_reg, stamp_next;
    logic [MagW-1:0]  dev_reg, dev_next;

    // detector state
    logic [MagW-1:0]  baseline_reg, baseline_next;
    logic [SumW-1:0]  sum_reg, sum_next;
    logic [CntW-1:0]  avg_count_reg, avg_count_next;
    logic [CntW-1:0]  avg_target_reg, avg_target_next;
    logic             collecting_reg, collecting_next;
    logic             hold_active_reg, hold_active_next;
    logic [StW-1:0]   hold_start_reg, hold_start_next;
    logic [1:0]       phase_reg, phase_next;
    logic [StW-1:0]   first_reg, first_next;
    logic [RateW-1:0] rate_reg, rate_next;

    // per-beat flags and divider role
    logic             seen_reg, seen_next;
    logic             motion_reg, motion_next;
    logic             avgf_reg, avgf_next;
    logic             div_rate_reg, div_rate_next;

    // output register
    logic                           m_tvalid_reg, m_tvalid_next;
    logic [brd_pkg::OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [brd_pkg::OUT_USER_W-1:0] m_tuser_reg, m_tuser_next;

    // shared divider
    logic             div_start;
    logic [SumW-1:0]  div_dividend;
    logic [StW-1:0]   div_divisor;
    logic             div_busy;
    logic             div_done;
    logic [SumW-1:0]  div_quo;

    // combinational helpers
    logic             s_accept;
    logic             out_free;
    logic             publish;
    logic [StW-1:0]   hold_age;
    logic [LimW-1:0]  dev_ext;
    logic [SumW-1:0]  sum_plus;
    logic [CntW-1:0]  cnt_inc;
    logic [StW-1:0]   span;

    brd_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    brd_div #(
        .DIVIDEND_W (SumW),
        .DIVISOR_W  (StW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign s_tready = (state_reg == brd_pkg::ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_free = !m_tvalid_reg || m_tready;
    assign publish  = (state_reg == brd_pkg::ST_DONE) && out_free;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    assign hold_age = stamp_reg - hold_start_reg;
    assign dev_ext  = LimW'(dev_reg);
    assign sum_plus = sum_reg + SumW'(mag_reg);
    assign cnt_inc  = avg_count_reg + CntW'(1);
    assign span     = stamp_reg - first_reg;

    // Sequencer: capture, holdoff/deviation, decision, divide, publish
    always_comb begin
        state_next       = state_reg;
        mag_next         = mag_reg;
        stamp_next       = stamp_reg;
        dev_next         = dev_reg;
        baseline_next    = baseline_reg;
        sum_next         = sum_reg;
        avg_count_next   = avg_count_reg;
        avg_target_next  = avg_target_reg;
        collecting_next  = collecting_reg;
        hold_active_next = hold_active_reg;
        hold_start_next  = hold_start_reg;
        phase_next       = phase_reg;
        first_next       = first_reg;
        rate_next        = rate_reg;
        seen_next        = seen_reg;
        motion_next      = motion_reg;
        avgf_next        = avgf_reg;
        div_rate_next    = div_rate_reg;
        m_tvalid_next    = m_tvalid_reg;
        m_tdata_next     = m_tdata_reg;
        m_tuser_next     = m_tuser_reg;
        div_start        = 1'b0;
        div_dividend     = sum_plus + SumW'(avg_target_reg >> 1);
        div_divisor      = StW'(avg_target_reg);

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        unique case (state_reg)
            brd_pkg::ST_IDLE: begin
                if (s_accept) begin
                    mag_next    = s_tdata[MagW-1:0];
                    stamp_next  = s_tdata[brd_pkg::MAG_FIELD_W +: StW];
                    seen_next   = 1'b0;
                    motion_next = 1'b0;
                    avgf_next   = 1'b0;
                    state_next  = brd_pkg::ST_HOLD;
                end
            end

            // holdoff expiry and deviation from the baseline
            brd_pkg::ST_HOLD: begin
                if (hold_active_reg && (hold_age > StW'(cfg.holdoff_ms))) begin
                    hold_active_next = 1'b0;
                end
                dev_next   = (mag_reg >= baseline_reg) ? mag_reg - baseline_reg
                                                       : baseline_reg - mag_reg;
                state_next = brd_pkg::ST_EVAL;
            end

            brd_pkg::ST_EVAL: begin
                state_next = brd_pkg::ST_DONE;
                if (collecting_reg) begin
                    // baseline average in progress
                    avgf_next      = 1'b1;
                    sum_next       = sum_plus;
                    avg_count_next = cnt_inc;
                    if (cnt_inc >= avg_target_reg) begin
                        collecting_next = 1'b0;
                        div_start       = 1'b1;
                        div_rate_next   = 1'b0;
                        state_next      = brd_pkg::ST_DIV;
                    end
                end else if (dev_ext > cfg.motion_limit) begin
                    motion_next = 1'b1;
                end else if ((dev_ext > cfg.rebase_limit) || (rate_reg > cfg.rate_ceiling)) begin
                    // start a new baseline
                    collecting_next = 1'b1;
                    avg_target_next = CntW'(REBASE_SAMPLES);
                    avg_count_next  = '0;
                    sum_next        = '0;
                    rate_next       = cfg.fallback_rate;
                    avgf_next       = 1'b1;
                end else if (!hold_active_reg && (dev_ext > cfg.breath_limit)) begin
                    seen_next        = 1'b1;
                    hold_active_next = 1'b1;
                    hold_start_next  = stamp_reg;
                    case (phase_reg)
                        brd_pkg::PH_ONE: phase_next = brd_pkg::PH_TWO;
                        brd_pkg::PH_TWO: begin
                            phase_next = brd_pkg::PH_NONE;
                            if (span == '0) begin
                                rate_next = brd_pkg::RATE_MAX;
                            end else begin
                                div_start     = 1'b1;
                                div_dividend  = SumW'(brd_pkg::RATE_NUM);
                                div_divisor   = span;
                                div_rate_next = 1'b1;
                                state_next    = brd_pkg::ST_DIV;
                            end
                        end
                        default: begin
                            first_next = stamp_reg;
                            phase_next = brd_pkg::PH_ONE;
                        end
                    endcase
                end
            end

            // wait for the shared divider, then take its quotient
            brd_pkg::ST_DIV: begin
                if (div_done) begin
                    if (div_rate_reg) begin
                        rate_next = (div_quo > SumW'(brd_pkg::RATE_MAX))
                                  ? brd_pkg::RATE_MAX : div_quo[RateW-1:0];
                    end else begin
                        baseline_next = div_quo[MagW-1:0];
                    end
                    state_next = brd_pkg::ST_DONE;
                end
            end

            brd_pkg::ST_DONE: begin
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {(brd_pkg::OUT_DATA_W - RateW - LimW)'(0),
                                     LimW'(baseline_reg), rate_reg};
                    m_tuser_next  = {avgf_reg, motion_reg, seen_reg};
                    state_next    = brd_pkg::ST_IDLE;
                end
            end

            default: state_next = brd_pkg::ST_IDLE;
        endcase
    end

    // control and architectural state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= brd_pkg::ST_IDLE;
            baseline_reg    <= '0;
            sum_reg         <= '0;
            avg_count_reg   <= '0;
            avg_target_reg  <= CntW'(CAL_SAMPLES);
            collecting_reg  <= 1'b1;
            hold_active_reg <= 1'b0;
            hold_start_reg  <= '0;
            phase_reg       <= brd_pkg::PH_NONE;
            first_reg       <= '0;
            rate_reg        <= '0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            state_reg       <= state_next;
            baseline_reg    <= baseline_next;
            sum_reg         <= sum_next;
            avg_count_reg   <= avg_count_next;
            avg_target_reg  <= avg_target_next;
            collecting_reg  <= collecting_next;
            hold_active_reg <= hold_active_next;
            hold_start_reg  <= hold_start_next;
            phase_reg       <= phase_next;
            first_reg       <= first_next;
            rate_reg        <= rate_next;
            m_tvalid_reg    <= m_tvalid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        mag_reg      <= mag_next;
        stamp_reg    <= stamp_next;
        dev_reg      <= dev_next;
        seen_reg     <= seen_next;
        motion_reg   <= motion_next;
        avgf_reg     <= avgf_next;
        div_rate_reg <= div_rate_next;
        m_tdata_reg  <= m_tdata_next;
        m_tuser_reg  <= m_tuser_next;
    end

    // checks
    `BRD_ASSERT_IMP(a_done_in_div, aclk, aresetn, div_done, state_reg == brd_pkg::ST_DIV)
    `BRD_ASSERT_IMP(a_start_in_eval, aclk, aresetn, div_start, (state_reg == brd_pkg::ST_EVAL) && !div_busy)
    `BRD_ASSERT_IMP(a_count_below_target, aclk, aresetn, collecting_reg, avg_count_reg < avg_target_reg)
    `BRD_ASSERT_NXT(a_publish, aclk, aresetn, publish, m_tvalid_reg && s_tready)

endmodule
